// File: rtl/c2p_pkg.sv
// ----------------------------------------------------------------------------
// c2p_pkg
// Shared types, constants and the arctangent table for the Cartesian to
// polar converter.
// ----------------------------------------------------------------------------
package c2p_pkg;

	// Rotation steps of the vectoring CORDIC; the table holds 24 entries
	localparam int ROTATION_STEPS = 16;
	localparam int ATAN_ENTRIES   = 24;
	localparam int STEPS_EFF      = (ROTATION_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES
	                                                                  : ROTATION_STEPS;
	// Square root of a 32-bit sum of squares takes one digit per cell
	localparam int SQRT_DIGITS    = 16;
	localparam int NUM_CELLS      = (STEPS_EFF > SQRT_DIGITS) ? STEPS_EFF : SQRT_DIGITS;

	// Datapath widths
	localparam int COORD_W = 16;
	localparam int VEC_W   = 27;  // |v| << 8 with CORDIC gain, signed
	localparam int Z_W     = 25;  // accumulated angle, degrees * 2^16, signed
	localparam int ATAN_W  = 22;
	localparam int STEP_W  = 5;
	localparam int S_W     = 2 * SQRT_DIGITS;
	localparam int ROOT_W  = SQRT_DIGITS;
	localparam int REM_W   = SQRT_DIGITS + 1;
	localparam int ANG_W   = 16;
	localparam int QUAD_W  = 3;

	// Angle constants, degrees * 2^7
	localparam logic [ANG_W-1:0] DEG0   = 16'd0;
	localparam logic [ANG_W-1:0] DEG90  = 16'd11520;
	localparam logic [ANG_W-1:0] DEG180 = 16'd23040;
	localparam logic [ANG_W-1:0] DEG270 = 16'd34560;
	localparam logic [ANG_W-1:0] DEG360 = 16'd46080;

	// Clamp limit of the first-quadrant angle, degrees * 2^16
	localparam logic signed [Z_W-1:0] Z_DEG90 = 25'sd5898240;

	// Quadrant codes
	localparam logic [QUAD_W-1:0] QUAD_AXIS = 3'd0;
	localparam logic [QUAD_W-1:0] QUAD_1    = 3'd1;
	localparam logic [QUAD_W-1:0] QUAD_2    = 3'd2;
	localparam logic [QUAD_W-1:0] QUAD_3    = 3'd3;
	localparam logic [QUAD_W-1:0] QUAD_4    = 3'd4;

	// Fixed angle for points on an axis (origin reads as positive x)
	typedef enum logic [1:0] {
		AXIS_POS_X,
		AXIS_POS_Y,
		AXIS_NEG_X,
		AXIS_NEG_Y
	} axis_t;

	typedef struct packed {
		logic [QUAD_W-1:0] quad;
		axis_t             axis;
	} tag_t;

	// Per-cell constants, tied off at the top level
	typedef struct packed {
		logic [STEP_W-1:0] step;
		logic              rot_en;
		logic              sqrt_en;
		logic [ATAN_W-1:0] atan;
	} cell_cfg_t;

	// Item state travelling down the chain
	typedef struct packed {
		logic signed [VEC_W-1:0] vx;
		logic signed [VEC_W-1:0] vy;
		logic signed [Z_W-1:0]   z;
		logic [S_W-1:0]          s;
		logic [REM_W-1:0]        rem;
		logic [ROOT_W-1:0]       root;
		tag_t                    tag;
	} cell_data_t;

	// atan(2^-i) in degrees * 2^16, rounded to nearest
	function automatic logic [ATAN_W-1:0] atan_deg_q16(input logic [STEP_W-1:0] idx);
		logic [ATAN_W-1:0] r;
		unique case (idx)
			5'd0:    r = 22'd2949120;
			5'd1:    r = 22'd1740967;
			5'd2:    r = 22'd919879;
			5'd3:    r = 22'd466945;
			5'd4:    r = 22'd234379;
			5'd5:    r = 22'd117304;
			5'd6:    r = 22'd58666;
			5'd7:    r = 22'd29335;
			5'd8:    r = 22'd14668;
			5'd9:    r = 22'd7334;
			5'd10:   r = 22'd3667;
			5'd11:   r = 22'd1833;
			5'd12:   r = 22'd917;
			5'd13:   r = 22'd458;
			5'd14:   r = 22'd229;
			5'd15:   r = 22'd115;
			5'd16:   r = 22'd57;
			5'd17:   r = 22'd29;
			5'd18:   r = 22'd14;
			5'd19:   r = 22'd7;
			5'd20:   r = 22'd4;
			5'd21:   r = 22'd2;
			5'd22:   r = 22'd1;
			default: r = 22'd0;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/c2p_cell.sv
// ----------------------------------------------------------------------------
// c2p_cell
// One cell of the chain: a CORDIC vectoring micro-rotation and one digit of
// the restoring square root, followed by the cell's item register.
// ----------------------------------------------------------------------------
module c2p_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  c2p_pkg::cell_cfg_t     cfg,
	input  logic                   prev_valid,
	input  c2p_pkg::cell_data_t    prev_data,
	output logic                   next_valid,
	output c2p_pkg::cell_data_t    next_data
);

	logic signed [c2p_pkg::VEC_W-1:0] vx, vy, sx, sy;
	logic signed [c2p_pkg::Z_W-1:0]   atan_z;
	logic [c2p_pkg::REM_W+1:0]        cur;
	logic [c2p_pkg::REM_W:0]          trial;
	c2p_pkg::cell_data_t              d;
	logic                             valid_q;
	c2p_pkg::cell_data_t              data_q;

	// Micro-rotation and square-root digit
	always_comb begin
		vx     = prev_data.vx;
		vy     = prev_data.vy;
		sx     = vx >>> cfg.step;
		sy     = vy >>> cfg.step;
		atan_z = $signed({{(c2p_pkg::Z_W-c2p_pkg::ATAN_W){1'b0}}, cfg.atan});
		cur    = {prev_data.rem, prev_data.s[c2p_pkg::S_W-1 -: 2]};
		trial  = {prev_data.root, 2'b01};
		d      = prev_data;
		if (cfg.rot_en) begin
			if (!vy[c2p_pkg::VEC_W-1]) begin
				d.vx = vx + sy;
				d.vy = vy - sx;
				d.z  = prev_data.z + atan_z;
			end else begin
				d.vx = vx - sy;
				d.vy = vy + sx;
				d.z  = prev_data.z - atan_z;
			end
		end
		if (cfg.sqrt_en) begin
			d.s = {prev_data.s[c2p_pkg::S_W-3:0], 2'b00};
			if (cur >= {1'b0, trial}) begin
				d.rem  = c2p_pkg::REM_W'(cur - {1'b0, trial});
				d.root = {prev_data.root[c2p_pkg::ROOT_W-2:0], 1'b1};
			end else begin
				d.rem  = cur[c2p_pkg::REM_W-1:0];
				d.root = {prev_data.root[c2p_pkg::ROOT_W-2:0], 1'b0};
			end
		end
	end

	// Item register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && prev_valid) begin
			data_q <= d;
		end
	end

	assign next_valid = valid_q;
	assign next_data  = data_q;

endmodule

// File: rtl/c2p_out.sv
// ----------------------------------------------------------------------------
// c2p_out
// Angle clamp, rounding and quadrant fold, magnitude rounding, then the
// output register with a one-item skid stage behind it.
// ----------------------------------------------------------------------------
module c2p_out (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              last_valid,
	input  c2p_pkg::cell_data_t               last_data,
	input  logic                              out_stall,
	output logic                              out_valid,
	output logic [c2p_pkg::ROOT_W-1:0]        magnitude,
	output logic [c2p_pkg::ANG_W-1:0]         angle_deg,
	output logic [c2p_pkg::QUAD_W-1:0]        quadrant,
	output logic                              full
);

	logic [c2p_pkg::Z_W-2:0]    zc;
	logic [c2p_pkg::Z_W-2:0]    zr;
	logic [c2p_pkg::ANG_W-1:0]  a;
	logic [c2p_pkg::ANG_W-1:0]  ang;
	logic [c2p_pkg::ROOT_W-1:0] mag;
	logic                       take, inc;

	logic                       out_v_q, skid_v_q;
	logic [c2p_pkg::ROOT_W-1:0] mag_q, skid_mag_q;
	logic [c2p_pkg::ANG_W-1:0]  ang_q, skid_ang_q;
	logic [c2p_pkg::QUAD_W-1:0] quad_q, skid_quad_q;

	// Clamp to [0, 90 deg], round to 7 fraction bits, fold by quadrant
	always_comb begin
		if (last_data.z[c2p_pkg::Z_W-1]) begin
			zc = '0;
		end else if (last_data.z > c2p_pkg::Z_DEG90) begin
			zc = c2p_pkg::Z_DEG90[c2p_pkg::Z_W-2:0];
		end else begin
			zc = last_data.z[c2p_pkg::Z_W-2:0];
		end
		zr = zc + (c2p_pkg::Z_W-1)'(256);
		a  = c2p_pkg::ANG_W'(zr[c2p_pkg::Z_W-2:9]);
		unique case (last_data.tag.quad)
			c2p_pkg::QUAD_1: ang = a;
			c2p_pkg::QUAD_2: ang = c2p_pkg::DEG180 - a;
			c2p_pkg::QUAD_3: ang = c2p_pkg::DEG180 + a;
			c2p_pkg::QUAD_4: ang = c2p_pkg::DEG360 - a;
			default: begin
				unique case (last_data.tag.axis)
					c2p_pkg::AXIS_POS_X: ang = c2p_pkg::DEG0;
					c2p_pkg::AXIS_POS_Y: ang = c2p_pkg::DEG90;
					c2p_pkg::AXIS_NEG_X: ang = c2p_pkg::DEG180;
					default:             ang = c2p_pkg::DEG270;
				endcase
			end
		endcase
		// full turn wraps to zero
		if (ang >= c2p_pkg::DEG360) begin
			ang = c2p_pkg::DEG0;
		end
		// round the root to nearest: remainder above root means upper half
		mag = last_data.root + c2p_pkg::ROOT_W'({1'b0, last_data.rem} > {2'b0, last_data.root});
	end

	assign take = out_v_q && !out_stall;
	assign inc  = last_valid && !skid_v_q;

	// Output register and skid stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (take) begin
				skid_v_q <= 1'b0;
			end
		end else if (inc) begin
			if (out_v_q && !take) begin
				skid_v_q <= 1'b1;
			end else begin
				out_v_q <= 1'b1;
			end
		end else if (take) begin
			out_v_q <= 1'b0;
		end
	end

	// Payload of both registers
	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (take) begin
				mag_q  <= skid_mag_q;
				ang_q  <= skid_ang_q;
				quad_q <= skid_quad_q;
			end
		end else if (inc) begin
			if (out_v_q && !take) begin
				skid_mag_q  <= mag;
				skid_ang_q  <= ang;
				skid_quad_q <= last_data.tag.quad;
			end else begin
				mag_q  <= mag;
				ang_q  <= ang;
				quad_q <= last_data.tag.quad;
			end
		end
	end

	assign out_valid = out_v_q;
	assign magnitude = mag_q;
	assign angle_deg = ang_q;
	assign quadrant  = quad_q;
	assign full      = skid_v_q;

endmodule

// File: rtl/cartesian_to_polar_unit.sv
// Path from the accepting input edge to the result: decode register, squares register,
//   one register per cell, then the output register.
// Throughput: one item per cycle; the chain moves on whenever the skid stage is empty.
// The cell count is the larger of the rotation steps (at most the 24 table entries) and the 16 square-root digits.
// Reset: asynchronous, active low; clears all valid bits, output and skid empty.
// ----------------------------------------------------------------------------
// cartesian_to_polar_unit
// Converts a signed Q8.8 point to magnitude, angle in degrees and quadrant,
// using a chain of CORDIC / square-root cells.
// ----------------------------------------------------------------------------
module cartesian_to_polar_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [c2p_pkg::COORD_W-1:0] coord_x,
	input  logic signed [c2p_pkg::COORD_W-1:0] coord_y,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [c2p_pkg::ROOT_W-1:0]         magnitude,
	output logic [c2p_pkg::ANG_W-1:0]          angle_deg,
	output logic [c2p_pkg::QUAD_W-1:0]         quadrant
);

	logic                         en, full;
	logic [c2p_pkg::COORD_W-1:0]  ax, ay;
	c2p_pkg::tag_t                tag;

	logic                         valid_s1, valid_s2;
	logic [c2p_pkg::COORD_W-1:0]  ax_s1, ay_s1;
	c2p_pkg::tag_t                tag_s1;
	c2p_pkg::cell_data_t          data_s2;

	logic                         chain_valid [c2p_pkg::NUM_CELLS+1];
	c2p_pkg::cell_data_t          chain_data  [c2p_pkg::NUM_CELLS+1];

	assign en       = !full;
	assign in_stall = full;

	// Absolute values and quadrant / axis decode
	always_comb begin
		ax = coord_x[c2p_pkg::COORD_W-1] ? c2p_pkg::COORD_W'(0 - coord_x) : coord_x;
		ay = coord_y[c2p_pkg::COORD_W-1] ? c2p_pkg::COORD_W'(0 - coord_y) : coord_y;
		tag.quad = c2p_pkg::QUAD_AXIS;
		tag.axis = c2p_pkg::AXIS_POS_X;
		if (coord_y == '0) begin
			tag.axis = coord_x[c2p_pkg::COORD_W-1] ? c2p_pkg::AXIS_NEG_X : c2p_pkg::AXIS_POS_X;
		end else if (coord_x == '0) begin
			tag.axis = coord_y[c2p_pkg::COORD_W-1] ? c2p_pkg::AXIS_NEG_Y : c2p_pkg::AXIS_POS_Y;
		end else begin
			unique case ({coord_x[c2p_pkg::COORD_W-1], coord_y[c2p_pkg::COORD_W-1]})
				2'b00:   tag.quad = c2p_pkg::QUAD_1;
				2'b10:   tag.quad = c2p_pkg::QUAD_2;
				2'b11:   tag.quad = c2p_pkg::QUAD_3;
				default: tag.quad = c2p_pkg::QUAD_4;
			endcase
		end
	end

	// Front stages: valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// Stage 1: decoded point
	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			ax_s1  <= ax;
			ay_s1  <= ay;
			tag_s1 <= tag;
		end
	end

	// Stage 2: sum of squares and CORDIC start vector
	always_ff @(posedge clk) begin
		if (en && valid_s1) begin
			data_s2.vx   <= $signed({3'b000, ax_s1, 8'h00});
			data_s2.vy   <= $signed({3'b000, ay_s1, 8'h00});
			data_s2.z    <= '0;
			data_s2.s    <= c2p_pkg::S_W'(ax_s1) * c2p_pkg::S_W'(ax_s1) +
			                c2p_pkg::S_W'(ay_s1) * c2p_pkg::S_W'(ay_s1);
			data_s2.rem  <= '0;
			data_s2.root <= '0;
			data_s2.tag  <= tag_s1;
		end
	end

	assign chain_valid[0] = valid_s2;
	assign chain_data[0]  = data_s2;

	// Chain of cells
	for (genvar i = 0; i < c2p_pkg::NUM_CELLS; i++) begin : g_cell
		localparam c2p_pkg::cell_cfg_t CFG = '{
			step:    c2p_pkg::STEP_W'(i),
			rot_en:  (i < c2p_pkg::STEPS_EFF),
			sqrt_en: (i < c2p_pkg::SQRT_DIGITS),
			atan:    c2p_pkg::atan_deg_q16(c2p_pkg::STEP_W'(i))
		};
		c2p_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (en),
			.cfg        (CFG),
			.prev_valid (chain_valid[i]),
			.prev_data  (chain_data[i]),
			.next_valid (chain_valid[i+1]),
			.next_data  (chain_data[i+1])
		);
	end

	// Final rounding, fold and output buffering
	c2p_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.last_valid (chain_valid[c2p_pkg::NUM_CELLS]),
		.last_data  (chain_data[c2p_pkg::NUM_CELLS]),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.magnitude  (magnitude),
		.angle_deg  (angle_deg),
		.quadrant   (quadrant),
		.full       (full)
	);

endmodule

// File: rtl/c2p_checker.sv
// ----------------------------------------------------------------------------
// c2p_port_checker
// Port-level checks on the converter's result channel, bound to the top.
// ----------------------------------------------------------------------------
module c2p_port_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               out_valid,
	input  logic                               out_stall,
	input  logic [c2p_pkg::ROOT_W-1:0]         magnitude,
	input  logic [c2p_pkg::ANG_W-1:0]          angle_deg,
	input  logic [c2p_pkg::QUAD_W-1:0]         quadrant
);

	// A stalled item stays on the port unchanged
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(magnitude) &&
		$stable(angle_deg) && $stable(quadrant))
		else $error("result item changed while stalled");

	// Angle is below a full turn and quadrant code is in range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (angle_deg < c2p_pkg::DEG360) && (quadrant <= c2p_pkg::QUAD_4))
		else $error("angle or quadrant out of range");

	// Points on an axis give one of the four axis angles
	a_axis: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (quadrant == c2p_pkg::QUAD_AXIS) |->
		(angle_deg == c2p_pkg::DEG0) || (angle_deg == c2p_pkg::DEG90) ||
		(angle_deg == c2p_pkg::DEG180) || (angle_deg == c2p_pkg::DEG270))
		else $error("axis item with off-axis angle");

	// Quadrant 2 angles lie between 90 and 180 degrees
	a_quad2: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (quadrant == c2p_pkg::QUAD_2) |->
		(angle_deg >= c2p_pkg::DEG90) && (angle_deg <= c2p_pkg::DEG180))
		else $error("quadrant 2 angle outside its quadrant");

endmodule

bind cartesian_to_polar_unit c2p_port_checker u_c2p_port_checker (.*);

// File: tb/c2p_checker.sv
// ----------------------------------------------------------------------------
// c2p_checker
// Watches both channels of the Cartesian to polar converter. It predicts
// magnitude, angle and quadrant for every accepted point and compares each
// accepted result with the oldest prediction still due.
// ----------------------------------------------------------------------------
module c2p_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_stall,
	input  logic signed [c2p_pkg::COORD_W-1:0] coord_x,
	input  logic signed [c2p_pkg::COORD_W-1:0] coord_y,
	input  logic                               out_valid,
	input  logic                               out_stall,
	input  logic [c2p_pkg::ROOT_W-1:0]         magnitude,
	input  logic [c2p_pkg::ANG_W-1:0]          angle_deg,
	input  logic [c2p_pkg::QUAD_W-1:0]         quadrant,
	output int                                 failures,
	output int                                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// Micro-rotations actually applied; the angle table stops at 24 entries
	localparam int N_ROT = (c2p_pkg::ROTATION_STEPS > 24) ? 24 : c2p_pkg::ROTATION_STEPS;

	typedef struct packed {
		logic [c2p_pkg::ROOT_W-1:0] mag;
		logic [c2p_pkg::ANG_W-1:0]  ang;
		logic [c2p_pkg::QUAD_W-1:0] quad;
	} polar_t;

	// atan(2^-i) in degrees, scaled by 2^16 and rounded
	longint atan_q16 [0:23] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	polar_t polar_due [$];
	int     reported = 0;

	initial begin
		failures = 0;
		pending  = 0;
	end

	// Polar form of one point: rounded root, folded CORDIC angle, quadrant
	function automatic polar_t cordic_polar(input logic signed [c2p_pkg::COORD_W-1:0] x,
	                                        input logic signed [c2p_pkg::COORD_W-1:0] y);
		polar_t p;
		longint ax, ay, vx, vy, sx, sy, z, s, r, t;
		int     a, ang;
		logic [c2p_pkg::QUAD_W-1:0] q;
		ax = (x < 0) ? -longint'(x) : longint'(x);
		ay = (y < 0) ? -longint'(y) : longint'(y);

		// Integer square root, then round to nearest
		s = ax * ax + ay * ay;
		r = 0;
		for (int b = 16; b >= 0; b--) begin
			t = r + (longint'(1) << b);
			if (t * t <= s)
				r = t;
		end
		if (s - r * r > r)
			r = r + 1;
		p.mag = r[c2p_pkg::ROOT_W-1:0];

		q = c2p_pkg::QUAD_AXIS;
		if (x == 0 && y == 0) begin
			ang = 0;
		end else if (y == 0) begin
			ang = (x > 0) ? 0 : int'(c2p_pkg::DEG180);
		end else if (x == 0) begin
			ang = (y > 0) ? int'(c2p_pkg::DEG90) : int'(c2p_pkg::DEG270);
		end else begin
			// Vectoring rotation of the first-quadrant copy towards the x axis
			vx = ax << 8;
			vy = ay << 8;
			z  = 0;
			for (int i = 0; i < N_ROT; i++) begin
				sx = vx >>> i;
				sy = vy >>> i;
				if (vy >= 0) begin
					vx = vx + sy;
					vy = vy - sx;
					z  = z + atan_q16[i];
				end else begin
					vx = vx - sy;
					vy = vy + sx;
					z  = z - atan_q16[i];
				end
			end
			if (z < 0)
				z = 0;
			if (z > longint'(90) * 65536)
				z = longint'(90) * 65536;
			a = int'((z + 256) >>> 9);

			// Fold into the full circle
			if (x > 0 && y > 0) begin
				ang = a;
				q   = c2p_pkg::QUAD_1;
			end else if (x < 0 && y > 0) begin
				ang = int'(c2p_pkg::DEG180) - a;
				q   = c2p_pkg::QUAD_2;
			end else if (x < 0) begin
				ang = int'(c2p_pkg::DEG180) + a;
				q   = c2p_pkg::QUAD_3;
			end else begin
				ang = int'(c2p_pkg::DEG360) - a;
				q   = c2p_pkg::QUAD_4;
			end
			if (ang >= int'(c2p_pkg::DEG360))
				ang = ang - int'(c2p_pkg::DEG360);
		end
		p.ang  = ang[c2p_pkg::ANG_W-1:0];
		p.quad = q;
		return p;
	endfunction

	// Compare the result leaving this edge, then queue the point entering it
	always @(posedge clk) begin
		polar_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (polar_due.size() == 0) begin
					failures++;
					if (reported < 10) begin
						reported++;
						$display("%0t: result with nothing due: mag %0d ang %0d quad %0d",
						         $realtime, magnitude, angle_deg, quadrant);
					end
				end else begin
					want = polar_due.pop_front();
					pending--;
					if (want.mag !== magnitude || want.ang !== angle_deg ||
					    want.quad !== quadrant) begin
						failures++;
						if (reported < 10) begin
							reported++;
							$display("%0t: mismatch: mag %0d/%0d ang %0d/%0d quad %0d/%0d",
							         $realtime, want.mag, magnitude, want.ang, angle_deg,
							         want.quad, quadrant);
						end
					end
				end
			end
			if (in_valid && !in_stall) begin
				polar_due.push_back(cordic_polar(coord_x, coord_y));
				pending++;
			end
		end
	end

endmodule

// File: tb/tb_cartesian_to_polar_unit.sv
// ----------------------------------------------------------------------------
// tb_cartesian_to_polar_unit
// Drives points into the Cartesian to polar converter: corner points and
// axes first, then a random mix of wide, small, axis, corner and diagonal
// points, with random gaps and output stalls. The checker does the scoring.
// ----------------------------------------------------------------------------
module tb_cartesian_to_polar_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM = 1050;
	localparam int TAIL     = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [c2p_pkg::COORD_W-1:0] coord_x = '0;
	logic signed [c2p_pkg::COORD_W-1:0] coord_y = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [c2p_pkg::ROOT_W-1:0] magnitude;
	logic [c2p_pkg::ANG_W-1:0]  angle_deg;
	logic [c2p_pkg::QUAD_W-1:0] quadrant;

	int failures;
	int pending;
	bit calm = 1'b0;  // no gaps and no stalls while set

	cartesian_to_polar_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.coord_x   (coord_x),
		.coord_y   (coord_y),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.magnitude (magnitude),
		.angle_deg (angle_deg),
		.quadrant  (quadrant)
	);

	c2p_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.coord_x   (coord_x),
		.coord_y   (coord_y),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.magnitude (magnitude),
		.angle_deg (angle_deg),
		.quadrant  (quadrant),
		.failures  (failures),
		.pending   (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Hard stop well beyond the slowest legal run
	initial begin
		#5ms;
		$display("Some tests failed");
		$finish;
	end

	// Offer one point after a random gap and hold it until taken
	task automatic send_point(input logic signed [c2p_pkg::COORD_W-1:0] x,
	                          input logic signed [c2p_pkg::COORD_W-1:0] y);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		coord_x  <= x;
		coord_y  <= y;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// Corner value of a coordinate
	function automatic logic signed [c2p_pkg::COORD_W-1:0] corner_value();
		logic signed [c2p_pkg::COORD_W-1:0] v;
		case ($urandom_range(0, 5))
			0:       v = -16'sd32768;
			1:       v = -16'sd32767;
			2:       v = -16'sd1;
			3:       v = 16'sd0;
			4:       v = 16'sd1;
			default: v = 16'sd32767;
		endcase
		return v;
	endfunction

	// Random point from a weighted mix of shapes
	task automatic pick_point(output logic signed [c2p_pkg::COORD_W-1:0] x,
	                          output logic signed [c2p_pkg::COORD_W-1:0] y);
		int kind;
		kind = $urandom_range(0, 9);
		x = c2p_pkg::COORD_W'($urandom);
		y = c2p_pkg::COORD_W'($urandom);
		if (kind == 5 || kind == 6) begin
			x = c2p_pkg::COORD_W'($urandom_range(0, 32) - 16);
			y = c2p_pkg::COORD_W'($urandom_range(0, 32) - 16);
		end else if (kind == 7) begin
			if ($urandom_range(0, 1))
				x = '0;
			else
				y = '0;
		end else if (kind == 8) begin
			x = corner_value();
			y = corner_value();
		end else if (kind == 9) begin
			// close to a diagonal, where the rotation sign flips late
			y = c2p_pkg::COORD_W'(($urandom_range(0, 1) ? x : -x) +
			                      ($urandom_range(0, 6) - 3));
		end
	endtask

	// Output side: random stall before each result, none while calm
	initial begin
		int hold;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			hold = calm ? 0 : $urandom_range(0, 10);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	// Stimulus and verdict
	initial begin
		logic signed [c2p_pkg::COORD_W-1:0] px, py;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Origin, the four axes, corners and unit points in every quadrant
		send_point(16'sd0, 16'sd0);
		send_point(16'sd256, 16'sd0);
		send_point(-16'sd256, 16'sd0);
		send_point(16'sd0, 16'sd256);
		send_point(16'sd0, -16'sd256);
		send_point(16'sd32767, 16'sd0);
		send_point(-16'sd32768, 16'sd0);
		send_point(16'sd0, 16'sd32767);
		send_point(16'sd0, -16'sd32768);
		send_point(16'sd32767, 16'sd32767);
		send_point(-16'sd32768, 16'sd32767);
		send_point(-16'sd32768, -16'sd32768);
		send_point(16'sd32767, -16'sd32768);
		send_point(16'sd1, 16'sd1);
		send_point(-16'sd1, 16'sd1);
		send_point(-16'sd1, -16'sd1);
		send_point(16'sd1, -16'sd1);
		send_point(16'sd32767, 16'sd1);
		send_point(16'sd1, 16'sd32767);
		send_point(-16'sd32768, -16'sd1);
		send_point(-16'sd1, -16'sd32768);
		send_point(16'sd32767, -16'sd1);

		// Let the pipe drain completely before the random part
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n % 50 == 0)
				calm = ($urandom_range(0, 3) == 0);
			pick_point(px, py);
			send_point(px, py);
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (TAIL) @(negedge clk);

		if (failures == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// File: filelist.f
rtl/c2p_pkg.sv
rtl/c2p_cell.sv
rtl/c2p_out.sv
rtl/cartesian_to_polar_unit.sv
rtl/c2p_checker.sv
tb/c2p_checker.sv
tb/tb_cartesian_to_polar_unit.sv
